>>> design/bso_pkg.sv
package bso_pkg;

    localparam int COORD_BITS = 20;
    localparam int SLOPE_FRAC = 10;
    // Coordinate differences need one extra bit.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    // Dividend is a difference shifted left by the fraction bits.
    localparam int NUM_BITS   = DIFF_BITS + SLOPE_FRAC;
    // Quotient magnitude fits the dividend width.
    localparam int QUO_BITS   = NUM_BITS + 1;
    localparam int PROD_BITS  = QUO_BITS + DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [QUO_BITS-1:0]   quo_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        coord_t box_left;
        coord_t box_right;
        coord_t box_top;
        coord_t box_bottom;
        coord_t seg_ax;
        coord_t seg_bx;
        coord_t seg_az;
        coord_t seg_bz;
    } query_t;

    // Early decision and the values carried into the crossing stages.
    typedef struct packed {
        logic   decided;
        logic   result;
        coord_t lo_a;
        coord_t hi_a;
        coord_t lo_b;
        coord_t hi_b;
        coord_t base_u;
        coord_t base_v;
        logic   num_neg;
        logic [NUM_BITS-1:0] num_mag;
        logic [DIFF_BITS-1:0] den;
        diff_t  off_lo;
        diff_t  off_hi;
    } axis_job_t;

endpackage

>>> design/bso_if.sv
interface bso_query_if;
    import bso_pkg::*;
    logic   valid;
    logic   ready;
    query_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bso_hit_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

>>> design/bso_divider.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitudes with a sign carried beside them. Side data travels with it.
module bso_divider
    import bso_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [NUM_BITS-1:0]   in_num,
    input  logic [DIFF_BITS-1:0]  in_den,
    input  logic                  in_neg,
    input  axis_job_t             in_side,
    output logic                  out_valid,
    output quo_t                  out_quo,
    output axis_job_t             out_side
);
    localparam int N = NUM_BITS;

    logic [N:1]              valid_reg;
    logic [N-1:0]            rem_reg  [1:N];
    logic [N-1:0]            quo_reg  [1:N];
    logic [DIFF_BITS-1:0]    den_reg  [1:N];
    logic                    neg_reg  [1:N];
    axis_job_t               side_reg [1:N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic                 v_in;
            logic [N-1:0]         rem_in;
            logic [N-1:0]         quo_in;
            logic [DIFF_BITS-1:0] den_in;
            logic                 neg_in;
            axis_job_t            side_in;
            logic [N:0]           trial;
            logic [N:0]           diff;

            // The first stage starts from a zero remainder.
            if (g == 0)
            begin : g_head
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign quo_in  = in_num;
                assign den_in  = in_den;
                assign neg_in  = in_neg;
                assign side_in = in_side;
            end
            else
            begin : g_body
                assign v_in    = valid_reg[g];
                assign rem_in  = rem_reg[g];
                assign quo_in  = quo_reg[g];
                assign den_in  = den_reg[g];
                assign neg_in  = neg_reg[g];
                assign side_in = side_reg[g];
            end

            assign trial = {rem_in, quo_in[N-1]};
            assign diff  = trial - {{(N+1-DIFF_BITS){1'b0}}, den_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g+1] <= 1'b0;
                else if (adv)
                    valid_reg[g+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!diff[N])
                        rem_reg[g+1] <= diff[N-1:0];
                    else
                        rem_reg[g+1] <= trial[N-1:0];
                    quo_reg[g+1]  <= {quo_in[N-2:0], ~diff[N]};
                    den_reg[g+1]  <= den_in;
                    neg_reg[g+1]  <= neg_in;
                    side_reg[g+1] <= side_in;
                end
            end
        end
    endgenerate

    logic [QUO_BITS-1:0] mag;
    assign mag       = {1'b0, quo_reg[N]};
    assign out_valid = valid_reg[N];
    assign out_quo   = neg_reg[N] ? quo_t'(-mag) : quo_t'(mag);
    assign out_side  = side_reg[N];
endmodule

>>> design/bso_axis_test.sv
// One axis pass: slope division, two crossing tests, early decision override.
module bso_axis_test
    import bso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  axis_job_t in_job,
    output logic      out_valid,
    output logic      out_hit
);
    logic      dv;
    quo_t      k;
    axis_job_t sd;

    bso_divider u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(in_valid), .in_num(in_job.num_mag), .in_den(in_job.den),
        .in_neg(in_job.num_neg), .in_side(in_job),
        .out_valid(dv), .out_quo(k), .out_side(sd)
    );

    // Stage 1: products.
    logic      p_valid_reg;
    prod_t     p_lo_reg, p_hi_reg;
    axis_job_t p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (adv)
            p_valid_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_lo_reg   <= k * sd.off_lo;
            p_hi_reg   <= k * sd.off_hi;
            p_side_reg <= sd;
        end
    end

    // Stage 2: crossings and compares.
    logic signed [CROSS_BITS-1:0] c_lo, c_hi, lo_b, hi_b;
    logic cross_hit;
    always_comb
    begin
        lo_b = CROSS_BITS'(p_side_reg.lo_b);
        hi_b = CROSS_BITS'(p_side_reg.hi_b);
        c_lo = CROSS_BITS'(p_side_reg.base_v) + CROSS_BITS'(p_lo_reg >>> SLOPE_FRAC);
        c_hi = CROSS_BITS'(p_side_reg.base_v) + CROSS_BITS'(p_hi_reg >>> SLOPE_FRAC);
        cross_hit = (c_lo >= lo_b && c_lo <= hi_b) || (c_hi >= lo_b && c_hi <= hi_b);
    end

    logic o_valid_reg, o_hit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_hit_reg <= p_side_reg.decided ? p_side_reg.result : cross_hit;
    end

    assign out_valid = o_valid_reg;
    assign out_hit   = o_hit_reg;
endmodule

>>> design/box_segment_overlap_test_unit.sv
// Box/segment overlap test. A request passes the request register, one
// divider stage per dividend bit, the product and the output register. Two
// axis passes run side by side; one request enters every cycle and the whole
// pipeline advances together whenever the output register is free.
module box_segment_overlap_test_unit
    import bso_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    bso_query_if.sink  query,
    bso_hit_if.source  result
);
    logic adv;
    assign adv         = !result.valid || result.ready;
    assign query.ready = adv;

    // Stage 0: register the request.
    logic   s0_valid_reg;
    query_t s0_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= query.valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            s0_reg <= query.data;
    end

    // Early decisions and setup of both axis passes.
    axis_job_t job_x, job_z;
    always_comb
    begin
        coord_t l, r, t, b, ax, bx, az, bz, x1, z1, x2, z2;
        diff_t  dzs, dxs, dxa, dza;
        logic   rej, ins, dec, res;
        l = s0_reg.box_left;  r = s0_reg.box_right;
        t = s0_reg.box_top;   b = s0_reg.box_bottom;
        ax = s0_reg.seg_ax;   bx = s0_reg.seg_bx;
        az = s0_reg.seg_az;   bz = s0_reg.seg_bz;
        rej = (ax > r && bx > r) || (ax < l && bx < l) ||
              (az > b && bz > b) || (az < t && bz < t);
        ins = (ax >= l && ax <= r && az >= t && az <= b) ||
              (bx >= l && bx <= r && bz >= t && bz <= b);
        dec = 1'b1;
        if (rej)
            res = 1'b0;
        else if (ins)
            res = 1'b1;
        else if (az == bz)
            res = (t <= az) && (b >= az);
        else if (ax == bx)
            res = (l <= ax) && (r >= ax);
        else
        begin
            res = 1'b0;
            dec = 1'b0;
        end

        if (ax > bx) begin x1 = bx; z1 = bz; x2 = ax; z2 = az; end
        else         begin x1 = ax; z1 = az; x2 = bx; z2 = bz; end
        dzs = DIFF_BITS'(z2) - DIFF_BITS'(z1);
        dxa = DIFF_BITS'(x2) - DIFF_BITS'(x1);
        job_x.decided = dec;
        job_x.result  = res;
        job_x.lo_a = l; job_x.hi_a = r; job_x.lo_b = t; job_x.hi_b = b;
        job_x.base_u = x1; job_x.base_v = z1;
        job_x.num_neg = dzs[DIFF_BITS-1];
        job_x.num_mag = {(dzs[DIFF_BITS-1] ? -dzs : dzs), {SLOPE_FRAC{1'b0}}};
        job_x.den    = dxa;
        job_x.off_lo = DIFF_BITS'(l) - DIFF_BITS'(x1);
        job_x.off_hi = DIFF_BITS'(r) - DIFF_BITS'(x1);

        if (az > bz) begin x1 = bx; z1 = bz; x2 = ax; z2 = az; end
        else         begin x1 = ax; z1 = az; x2 = bx; z2 = bz; end
        // Ties in z never reach the crossing stage, so the order is free.
        dxs = DIFF_BITS'(x2) - DIFF_BITS'(x1);
        dza = DIFF_BITS'(z2) - DIFF_BITS'(z1);
        // An early decision overrides the crossing result in both passes.
        job_z.decided = dec;
        job_z.result  = res;
        job_z.lo_a = t; job_z.hi_a = b; job_z.lo_b = l; job_z.hi_b = r;
        job_z.base_u = z1; job_z.base_v = x1;
        job_z.num_neg = dxs[DIFF_BITS-1];
        job_z.num_mag = {(dxs[DIFF_BITS-1] ? -dxs : dxs), {SLOPE_FRAC{1'b0}}};
        job_z.den    = dza;
        job_z.off_lo = DIFF_BITS'(t) - DIFF_BITS'(z1);
        job_z.off_hi = DIFF_BITS'(b) - DIFF_BITS'(z1);
    end

    logic vx, hx, vz, hz;
    bso_axis_test u_x (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s0_valid_reg),
        .in_job(job_x), .out_valid(vx), .out_hit(hx)
    );
    bso_axis_test u_z (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s0_valid_reg),
        .in_job(job_z), .out_valid(vz), .out_hit(hz)
    );

    assign result.valid = vx;
    assign result.hit   = hx || hz;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) vx == vz)
        else $error("axis lanes out of step");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.hit))
        else $error("result changed under stall");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> query.ready)
        else $error("input blocked with empty output");
endmodule
